// ===== rtl/core/html_entity_decoder_macros.svh =====
// Assertion macros used by the decoder back end.
`ifndef HTML_ENTITY_DECODER_MACROS_SVH
`define HTML_ENTITY_DECODER_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define HED_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define HED_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/hed_pkg.sv =====
// ----------------------------------------------------------------------------
// hed_pkg
// Constants, request types and the named entity table of the decoder.
// ----------------------------------------------------------------------------
package hed_pkg;

  localparam logic [7:0] AMP  = 8'h26;
  localparam logic [7:0] SEMI = 8'h3B;

  // Longest entity name, without the ampersand.
  localparam int NAME_MAX   = 7;
  localparam int TABLE_SIZE = 256;

  typedef struct packed {
    logic        valid;
    logic [55:0] name;
    logic [2:0]  nlen;
    logic [1:0]  rlen;
    logic [23:0] rep;
  } entity_t;

  // Control part of one request from the front end to the back end.
  typedef struct packed {
    logic       last;
    logic       tail_valid;
    logic [7:0] tail;
  } cmd_ctl_t;

  function automatic entity_t mk(logic [55:0] n, logic [2:0] nl, logic [1:0] rl,
                                 logic [23:0] rp);
    entity_t e;
    e.valid = 1'b1;
    e.name  = n;
    e.nlen  = nl;
    e.rlen  = rl;
    e.rep   = rp;
    return e;
  endfunction

  // Name is right aligned, replacement bytes start at the top of rep.
  function automatic entity_t entity_row(logic [7:0] r);
    entity_t e;
    e = '0;
    case (r)
      8'd0:   e = mk("nbsp",   3'd4, 2'd1, 24'h200000);
      8'd1:   e = mk("lt",     3'd2, 2'd1, 24'h3C0000);
      8'd2:   e = mk("gt",     3'd2, 2'd1, 24'h3E0000);
      8'd3:   e = mk("amp",    3'd3, 2'd1, 24'h260000);
      8'd4:   e = mk("quot",   3'd4, 2'd1, 24'h220000);
      8'd5:   e = mk("apos",   3'd4, 2'd1, 24'h270000);
      8'd6:   e = mk("#39",    3'd3, 2'd1, 24'h270000);
      8'd7:   e = mk("copy",   3'd4, 2'd2, 24'hC2A900);
      8'd8:   e = mk("reg",    3'd3, 2'd2, 24'hC2AE00);
      8'd9:   e = mk("trade",  3'd5, 2'd3, 24'hE284A2);
      8'd10:  e = mk("euro",   3'd4, 2'd3, 24'hE282AC);
      8'd11:  e = mk("pound",  3'd5, 2'd2, 24'hC2A300);
      8'd12:  e = mk("yen",    3'd3, 2'd2, 24'hC2A500);
      8'd13:  e = mk("cent",   3'd4, 2'd2, 24'hC2A200);
      8'd14:  e = mk("sect",   3'd4, 2'd2, 24'hC2A700);
      8'd15:  e = mk("para",   3'd4, 2'd2, 24'hC2B600);
      8'd16:  e = mk("middot", 3'd6, 2'd2, 24'hC2B700);
      8'd17:  e = mk("bull",   3'd4, 2'd3, 24'hE280A2);
      8'd18:  e = mk("hellip", 3'd6, 2'd3, 24'h2E2E2E);
      8'd19:  e = mk("ndash",  3'd5, 2'd1, 24'h2D0000);
      8'd20:  e = mk("mdash",  3'd5, 2'd1, 24'h2D0000);
      8'd21:  e = mk("laquo",  3'd5, 2'd2, 24'hC2AB00);
      8'd22:  e = mk("raquo",  3'd5, 2'd2, 24'hC2BB00);
      8'd23:  e = mk("deg",    3'd3, 2'd2, 24'hC2B000);
      8'd24:  e = mk("plusmn", 3'd6, 2'd2, 24'hC2B100);
      8'd25:  e = mk("times",  3'd5, 2'd2, 24'hC39700);
      8'd26:  e = mk("divide", 3'd6, 2'd2, 24'hC3B700);
      8'd27:  e = mk("micro",  3'd5, 2'd2, 24'hC2B500);
      8'd28:  e = mk("iexcl",  3'd5, 2'd2, 24'hC2A100);
      8'd29:  e = mk("iquest", 3'd6, 2'd2, 24'hC2BF00);
      8'd30:  e = mk("brvbar", 3'd6, 2'd1, 24'h7C0000);
      8'd31:  e = mk("not",    3'd3, 2'd2, 24'hC2AC00);
      8'd32:  e = mk("shy",    3'd3, 2'd1, 24'h2D0000);
      8'd33:  e = mk("macr",   3'd4, 2'd2, 24'hC2AF00);
      8'd34:  e = mk("uml",    3'd3, 2'd2, 24'hC2A800);
      8'd35:  e = mk("ordf",   3'd4, 2'd2, 24'hC2AA00);
      8'd36:  e = mk("ordm",   3'd4, 2'd2, 24'hC2BA00);
      8'd37:  e = mk("sup1",   3'd4, 2'd1, 24'h310000);
      8'd38:  e = mk("sup2",   3'd4, 2'd1, 24'h320000);
      8'd39:  e = mk("sup3",   3'd4, 2'd1, 24'h330000);
      8'd40:  e = mk("frac14", 3'd6, 2'd3, 24'h312F34);
      8'd41:  e = mk("frac12", 3'd6, 2'd3, 24'h312F32);
      8'd42:  e = mk("frac34", 3'd6, 2'd3, 24'h332F34);
      8'd43:  e = mk("Agrave", 3'd6, 2'd2, 24'hC38000);
      8'd44:  e = mk("Aacute", 3'd6, 2'd2, 24'hC38100);
      8'd45:  e = mk("Acirc",  3'd5, 2'd2, 24'hC38200);
      8'd46:  e = mk("Atilde", 3'd6, 2'd2, 24'hC38300);
      8'd47:  e = mk("Auml",   3'd4, 2'd2, 24'hC38400);
      8'd48:  e = mk("Aring",  3'd5, 2'd2, 24'hC38500);
      8'd49:  e = mk("AElig",  3'd5, 2'd2, 24'hC38600);
      8'd50:  e = mk("Ccedil", 3'd6, 2'd2, 24'hC38700);
      8'd51:  e = mk("Egrave", 3'd6, 2'd2, 24'hC38800);
      8'd52:  e = mk("Eacute", 3'd6, 2'd2, 24'hC38900);
      8'd53:  e = mk("Ecirc",  3'd5, 2'd2, 24'hC38A00);
      8'd54:  e = mk("Euml",   3'd4, 2'd2, 24'hC38B00);
      8'd55:  e = mk("Igrave", 3'd6, 2'd2, 24'hC38C00);
      8'd56:  e = mk("Iacute", 3'd6, 2'd2, 24'hC38D00);
      8'd57:  e = mk("Icirc",  3'd5, 2'd2, 24'hC38E00);
      8'd58:  e = mk("Iuml",   3'd4, 2'd2, 24'hC38F00);
      8'd59:  e = mk("ETH",    3'd3, 2'd2, 24'hC39000);
      8'd60:  e = mk("Ntilde", 3'd6, 2'd2, 24'hC39100);
      8'd61:  e = mk("Ograve", 3'd6, 2'd2, 24'hC39200);
      8'd62:  e = mk("Oacute", 3'd6, 2'd2, 24'hC39300);
      8'd63:  e = mk("Ocirc",  3'd5, 2'd2, 24'hC39400);
      8'd64:  e = mk("Otilde", 3'd6, 2'd2, 24'hC39500);
      8'd65:  e = mk("Ouml",   3'd4, 2'd2, 24'hC39600);
      8'd66:  e = mk("Oslash", 3'd6, 2'd2, 24'hC39800);
      8'd67:  e = mk("Ugrave", 3'd6, 2'd2, 24'hC39900);
      8'd68:  e = mk("Uacute", 3'd6, 2'd2, 24'hC39A00);
      8'd69:  e = mk("Ucirc",  3'd5, 2'd2, 24'hC39B00);
      8'd70:  e = mk("Uuml",   3'd4, 2'd2, 24'hC39C00);
      8'd71:  e = mk("Yacute", 3'd6, 2'd2, 24'hC39D00);
      8'd72:  e = mk("THORN",  3'd5, 2'd2, 24'hC39E00);
      8'd73:  e = mk("szlig",  3'd5, 2'd2, 24'hC39F00);
      8'd74:  e = mk("agrave", 3'd6, 2'd2, 24'hC3A000);
      8'd75:  e = mk("aacute", 3'd6, 2'd2, 24'hC3A100);
      8'd76:  e = mk("acirc",  3'd5, 2'd2, 24'hC3A200);
      8'd77:  e = mk("atilde", 3'd6, 2'd2, 24'hC3A300);
      8'd78:  e = mk("auml",   3'd4, 2'd2, 24'hC3A400);
      8'd79:  e = mk("aring",  3'd5, 2'd2, 24'hC3A500);
      8'd80:  e = mk("aelig",  3'd5, 2'd2, 24'hC3A600);
      8'd81:  e = mk("ccedil", 3'd6, 2'd2, 24'hC3A700);
      8'd82:  e = mk("egrave", 3'd6, 2'd2, 24'hC3A800);
      8'd83:  e = mk("eacute", 3'd6, 2'd2, 24'hC3A900);
      8'd84:  e = mk("ecirc",  3'd5, 2'd2, 24'hC3AA00);
      8'd85:  e = mk("euml",   3'd4, 2'd2, 24'hC3AB00);
      8'd86:  e = mk("igrave", 3'd6, 2'd2, 24'hC3AC00);
      8'd87:  e = mk("iacute", 3'd6, 2'd2, 24'hC3AD00);
      8'd88:  e = mk("icirc",  3'd5, 2'd2, 24'hC3AE00);
      8'd89:  e = mk("iuml",   3'd4, 2'd2, 24'hC3AF00);
      8'd90:  e = mk("eth",    3'd3, 2'd2, 24'hC3B000);
      8'd91:  e = mk("ntilde", 3'd6, 2'd2, 24'hC3B100);
      8'd92:  e = mk("ograve", 3'd6, 2'd2, 24'hC3B200);
      8'd93:  e = mk("oacute", 3'd6, 2'd2, 24'hC3B300);
      8'd94:  e = mk("ocirc",  3'd5, 2'd2, 24'hC3B400);
      8'd95:  e = mk("otilde", 3'd6, 2'd2, 24'hC3B500);
      8'd96:  e = mk("ouml",   3'd4, 2'd2, 24'hC3B600);
      8'd97:  e = mk("oslash", 3'd6, 2'd2, 24'hC3B800);
      8'd98:  e = mk("ugrave", 3'd6, 2'd2, 24'hC3B900);
      8'd99:  e = mk("uacute", 3'd6, 2'd2, 24'hC3BA00);
      8'd100: e = mk("ucirc",  3'd5, 2'd2, 24'hC3BB00);
      8'd101: e = mk("uuml",   3'd4, 2'd2, 24'hC3BC00);
      8'd102: e = mk("yacute", 3'd6, 2'd2, 24'hC3BD00);
      8'd103: e = mk("thorn",  3'd5, 2'd2, 24'hC3BE00);
      8'd104: e = mk("yuml",   3'd4, 2'd2, 24'hC3BF00);
      8'd105: e = mk("Alpha",  3'd5, 2'd2, 24'hCE9100);
      8'd106: e = mk("Beta",   3'd4, 2'd2, 24'hCE9200);
      8'd107: e = mk("Gamma",  3'd5, 2'd2, 24'hCE9300);
      8'd108: e = mk("Delta",  3'd5, 2'd2, 24'hCE9400);
      8'd109: e = mk("Epsilon", 3'd7, 2'd2, 24'hCE9500);
      8'd110: e = mk("Zeta",   3'd4, 2'd2, 24'hCE9600);
      8'd111: e = mk("Eta",    3'd3, 2'd2, 24'hCE9700);
      8'd112: e = mk("Theta",  3'd5, 2'd2, 24'hCE9800);
      8'd113: e = mk("Iota",   3'd4, 2'd2, 24'hCE9900);
      8'd114: e = mk("Kappa",  3'd5, 2'd2, 24'hCE9A00);
      8'd115: e = mk("Lambda", 3'd6, 2'd2, 24'hCE9B00);
      8'd116: e = mk("Mu",     3'd2, 2'd2, 24'hCE9C00);
      8'd117: e = mk("Nu",     3'd2, 2'd2, 24'hCE9D00);
      8'd118: e = mk("Xi",     3'd2, 2'd2, 24'hCE9E00);
      8'd119: e = mk("Omicron", 3'd7, 2'd2, 24'hCE9F00);
      8'd120: e = mk("Pi",     3'd2, 2'd2, 24'hCEA000);
      8'd121: e = mk("Rho",    3'd3, 2'd2, 24'hCEA100);
      8'd122: e = mk("Sigma",  3'd5, 2'd2, 24'hCEA300);
      8'd123: e = mk("Tau",    3'd3, 2'd2, 24'hCEA400);
      8'd124: e = mk("Upsilon", 3'd7, 2'd2, 24'hCEA500);
      8'd125: e = mk("Phi",    3'd3, 2'd2, 24'hCEA600);
      8'd126: e = mk("Chi",    3'd3, 2'd2, 24'hCEA700);
      8'd127: e = mk("Psi",    3'd3, 2'd2, 24'hCEA800);
      8'd128: e = mk("Omega",  3'd5, 2'd2, 24'hCEA900);
      8'd129: e = mk("alpha",  3'd5, 2'd2, 24'hCEB100);
      8'd130: e = mk("beta",   3'd4, 2'd2, 24'hCEB200);
      8'd131: e = mk("gamma",  3'd5, 2'd2, 24'hCEB300);
      8'd132: e = mk("delta",  3'd5, 2'd2, 24'hCEB400);
      8'd133: e = mk("epsilon", 3'd7, 2'd2, 24'hCEB500);
      8'd134: e = mk("zeta",   3'd4, 2'd2, 24'hCEB600);
      8'd135: e = mk("eta",    3'd3, 2'd2, 24'hCEB700);
      8'd136: e = mk("theta",  3'd5, 2'd2, 24'hCEB800);
      8'd137: e = mk("iota",   3'd4, 2'd2, 24'hCEB900);
      8'd138: e = mk("kappa",  3'd5, 2'd2, 24'hCEBA00);
      8'd139: e = mk("lambda", 3'd6, 2'd2, 24'hCEBB00);
      8'd140: e = mk("mu",     3'd2, 2'd2, 24'hCEBC00);
      8'd141: e = mk("nu",     3'd2, 2'd2, 24'hCEBD00);
      8'd142: e = mk("xi",     3'd2, 2'd2, 24'hCEBE00);
      8'd143: e = mk("omicron", 3'd7, 2'd2, 24'hCEBF00);
      8'd144: e = mk("pi",     3'd2, 2'd2, 24'hCF8000);
      8'd145: e = mk("rho",    3'd3, 2'd2, 24'hCF8100);
      8'd146: e = mk("sigma",  3'd5, 2'd2, 24'hCF8300);
      8'd147: e = mk("tau",    3'd3, 2'd2, 24'hCF8400);
      8'd148: e = mk("upsilon", 3'd7, 2'd2, 24'hCF8500);
      8'd149: e = mk("phi",    3'd3, 2'd2, 24'hCF8600);
      8'd150: e = mk("chi",    3'd3, 2'd2, 24'hCF8700);
      8'd151: e = mk("psi",    3'd3, 2'd2, 24'hCF8800);
      8'd152: e = mk("omega",  3'd5, 2'd2, 24'hCF8900);
      8'd153: e = mk("forall", 3'd6, 2'd3, 24'hE28880);
      8'd154: e = mk("part",   3'd4, 2'd3, 24'hE28882);
      8'd155: e = mk("exist",  3'd5, 2'd3, 24'hE28883);
      8'd156: e = mk("empty",  3'd5, 2'd3, 24'hE28885);
      8'd157: e = mk("nabla",  3'd5, 2'd3, 24'hE28887);
      8'd158: e = mk("isin",   3'd4, 2'd3, 24'hE28888);
      8'd159: e = mk("notin",  3'd5, 2'd3, 24'hE28889);
      8'd160: e = mk("ni",     3'd2, 2'd3, 24'hE2888B);
      8'd161: e = mk("prod",   3'd4, 2'd3, 24'hE2888F);
      8'd162: e = mk("sum",    3'd3, 2'd3, 24'hE28891);
      8'd163: e = mk("minus",  3'd5, 2'd1, 24'h2D0000);
      8'd164: e = mk("lowast", 3'd6, 2'd1, 24'h2A0000);
      8'd165: e = mk("radic",  3'd5, 2'd3, 24'hE2889A);
      8'd166: e = mk("prop",   3'd4, 2'd3, 24'hE2889D);
      8'd167: e = mk("infin",  3'd5, 2'd3, 24'hE2889E);
      8'd168: e = mk("ang",    3'd3, 2'd3, 24'hE288A0);
      8'd169: e = mk("and",    3'd3, 2'd3, 24'hE288A7);
      8'd170: e = mk("or",     3'd2, 2'd3, 24'hE288A8);
      8'd171: e = mk("cap",    3'd3, 2'd3, 24'hE288A9);
      8'd172: e = mk("int",    3'd3, 2'd3, 24'hE288AB);
      8'd173: e = mk("there4", 3'd6, 2'd3, 24'hE288B4);
      8'd174: e = mk("cong",   3'd4, 2'd3, 24'hE28985);
      8'd175: e = mk("asymp",  3'd5, 2'd3, 24'hE28988);
      8'd176: e = mk("ne",     3'd2, 2'd3, 24'hE289A0);
      8'd177: e = mk("equiv",  3'd5, 2'd3, 24'hE289A1);
      8'd178: e = mk("le",     3'd2, 2'd3, 24'hE289A4);
      8'd179: e = mk("ge",     3'd2, 2'd3, 24'hE289A5);
      8'd180: e = mk("sub",    3'd3, 2'd3, 24'hE28A82);
      8'd181: e = mk("sup",    3'd3, 2'd3, 24'hE28A83);
      8'd182: e = mk("nsub",   3'd4, 2'd3, 24'hE28A84);
      8'd183: e = mk("sube",   3'd4, 2'd3, 24'hE28A86);
      8'd184: e = mk("supe",   3'd4, 2'd3, 24'hE28A87);
      8'd185: e = mk("oplus",  3'd5, 2'd3, 24'hE28A95);
      8'd186: e = mk("otimes", 3'd6, 2'd3, 24'hE28A97);
      8'd187: e = mk("perp",   3'd4, 2'd3, 24'hE28AA5);
      8'd188: e = mk("sdot",   3'd4, 2'd3, 24'hE28B85);
      8'd189: e = mk("larr",   3'd4, 2'd3, 24'hE28690);
      8'd190: e = mk("uarr",   3'd4, 2'd3, 24'hE28691);
      8'd191: e = mk("rarr",   3'd4, 2'd3, 24'hE28692);
      8'd192: e = mk("darr",   3'd4, 2'd3, 24'hE28693);
      8'd193: e = mk("harr",   3'd4, 2'd3, 24'hE28694);
      8'd194: e = mk("crarr",  3'd5, 2'd3, 24'hE286B5);
      8'd195: e = mk("lArr",   3'd4, 2'd3, 24'hE28790);
      8'd196: e = mk("uArr",   3'd4, 2'd3, 24'hE28791);
      8'd197: e = mk("rArr",   3'd4, 2'd3, 24'hE28792);
      8'd198: e = mk("dArr",   3'd4, 2'd3, 24'hE28793);
      8'd199: e = mk("hArr",   3'd4, 2'd3, 24'hE28794);
      8'd200: e = mk("spades", 3'd6, 2'd3, 24'hE299A0);
      8'd201: e = mk("clubs",  3'd5, 2'd3, 24'hE299A3);
      8'd202: e = mk("hearts", 3'd6, 2'd3, 24'hE299A5);
      8'd203: e = mk("diams",  3'd5, 2'd3, 24'hE299A6);
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

// ===== rtl/core/hed_queue.sv =====
// ----------------------------------------------------------------------------
// hed_queue
// Two-entry request queue between the front end and the back end.
// ----------------------------------------------------------------------------
module hed_queue #(
  parameter int WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  logic [1:0][WIDTH-1:0] slots;
  logic                  wptr;
  logic                  rptr;
  logic [1:0]            fill;

  assign full  = (fill == 2'd2);
  assign empty = (fill == 2'd0);
  assign dout  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wptr] <= din;
    end
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push && !full) wptr <= ~wptr;
      if (pop && !empty) rptr <= ~rptr;
      fill <= fill + {1'b0, push && !full} - {1'b0, pop && !empty};
    end
  end

endmodule

// ===== rtl/core/hed_front.sv =====
// ----------------------------------------------------------------------------
// hed_front
// Takes input bytes, holds entity names and turns the bytes into emit requests:
// each a run of held or replacement bytes plus an optional tail byte.
// ----------------------------------------------------------------------------
module hed_front
  import hed_pkg::*;
#(
  parameter int BUFFER_DEPTH = 8,
  parameter int CW           = $clog2(BUFFER_DEPTH + 2)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [7:0]                  in_byte,
  input  logic                        in_last,
  output logic                        q_push,
  input  logic                        q_full,
  output cmd_ctl_t                    cmd_ctl,
  output logic [CW-1:0]               cmd_count,
  output logic [BUFFER_DEPTH-1:0][7:0] cmd_bytes
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_MATCH = 1'b1;

  logic                         state;
  logic                         collecting;
  logic [BUFFER_DEPTH-1:0][7:0] held;
  logic [CW-1:0]                hc;
  logic                         hit_q;
  logic [7:0]                   row_q;
  logic                         last_q;

  logic        accept;
  logic [55:0] key;
  logic [2:0]  klen;
  logic        klen_ok;
  logic        hit;
  logic [7:0]  row;
  entity_t     e;
  entity_t     rep_e;

  assign full   = (state == ST_MATCH) || q_full;
  assign accept = push && !full;

  // Name key from the held bytes after the ampersand, right aligned.
  always_comb begin
    key = '0;
    for (int j = 1; j <= NAME_MAX; j++) begin
      if (CW'(j) < hc) key = {key[47:0], held[j]};
    end
    klen_ok = (hc >= CW'(1)) && (hc <= CW'(NAME_MAX + 1));
    klen    = 3'(hc - CW'(1));
    hit = 1'b0;
    row = '0;
    for (int r = 0; r < TABLE_SIZE; r++) begin
      e = entity_row(8'(r));
      if (e.valid && klen_ok && (e.nlen == klen) && (e.name == key)) begin
        hit = 1'b1;
        row = row | 8'(r);
      end
    end
  end

  assign rep_e = entity_row(row_q);

  always_comb begin
    q_push             = 1'b0;
    cmd_ctl.last       = in_last;
    cmd_ctl.tail_valid = 1'b0;
    cmd_ctl.tail       = in_byte;
    cmd_count          = hc;
    cmd_bytes          = held;
    if (state == ST_MATCH) begin
      q_push       = 1'b1;
      cmd_ctl.last = last_q;
      if (hit_q) begin
        cmd_bytes    = '0;
        cmd_bytes[0] = rep_e.rep[23:16];
        cmd_bytes[1] = rep_e.rep[15:8];
        cmd_bytes[2] = rep_e.rep[7:0];
        cmd_count    = CW'(rep_e.rlen);
      end else begin
        cmd_ctl.tail_valid = 1'b1;
        cmd_ctl.tail       = SEMI;
      end
    end else if (accept) begin
      if (collecting) begin
        if (in_byte == AMP) begin
          // The new ampersand is flushed at once when the string ends here.
          q_push             = 1'b1;
          cmd_ctl.tail_valid = in_last;
        end else if (in_byte != SEMI) begin
          if (hc < CW'(BUFFER_DEPTH)) begin
            q_push = in_last;
            for (int k = 0; k < BUFFER_DEPTH; k++) begin
              if (CW'(k) == hc) cmd_bytes[k] = in_byte;
            end
            cmd_count = hc + CW'(1);
          end else begin
            q_push             = 1'b1;
            cmd_ctl.tail_valid = 1'b1;
          end
        end
      end else if (in_byte == AMP) begin
        q_push       = in_last;
        cmd_bytes[0] = AMP;
        cmd_count    = CW'(1);
      end else begin
        q_push             = 1'b1;
        cmd_count          = '0;
        cmd_ctl.tail_valid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (in_byte == AMP) begin
        held[0] <= AMP;
      end else if (collecting && in_byte != SEMI) begin
        for (int k = 0; k < BUFFER_DEPTH; k++) begin
          if (CW'(k) == hc) held[k] <= in_byte;
        end
      end
      hit_q  <= hit;
      row_q  <= row;
      last_q <= in_last;
    end
    if (rst) begin
      state      <= ST_IDLE;
      collecting <= 1'b0;
      hc         <= '0;
    end else if (state == ST_MATCH) begin
      if (!q_full) begin
        state      <= ST_IDLE;
        collecting <= 1'b0;
        hc         <= '0;
      end
    end else if (accept) begin
      if (collecting && in_byte == SEMI) begin
        state <= ST_MATCH;
      end else if (in_byte == AMP) begin
        collecting <= !in_last;
        hc         <= in_last ? '0 : CW'(1);
      end else if (collecting && hc < CW'(BUFFER_DEPTH) && !in_last) begin
        hc <= hc + CW'(1);
      end else begin
        collecting <= 1'b0;
        hc         <= '0;
      end
    end
  end

endmodule

// ===== rtl/core/hed_back.sv =====
// ----------------------------------------------------------------------------
// hed_back
// Writes request bytes to the output register, one per cycle unless stalled.
// ----------------------------------------------------------------------------
`include "html_entity_decoder_macros.svh"

module hed_back
  import hed_pkg::*;
#(
  parameter int BUFFER_DEPTH = 8,
  parameter int CW           = $clog2(BUFFER_DEPTH + 2)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_empty,
  output logic                         q_pop,
  input  cmd_ctl_t                     cmd_ctl,
  input  logic [CW-1:0]                cmd_count,
  input  logic [BUFFER_DEPTH-1:0][7:0] cmd_bytes,
  output logic                         empty,
  input  logic                         pop,
  output logic [7:0]                   out_byte,
  output logic                         run_end,
  output logic                         string_end
);

  localparam int IW = $clog2(BUFFER_DEPTH);

  logic                         busy;
  logic [CW-1:0]                idx;
  cmd_ctl_t                     cur_ctl;
  logic [CW-1:0]                cur_count;
  logic [BUFFER_DEPTH-1:0][7:0] cur_bytes;
  logic                         out_valid;

  logic [CW-1:0] total;
  logic          emit;
  logic          final_byte;
  logic [7:0]    sel_byte;

  assign total      = cur_count + CW'(cur_ctl.tail_valid);
  assign q_pop      = !busy && !q_empty;
  assign emit       = busy && (!out_valid || pop);
  assign final_byte = (idx == total - CW'(1));
  assign sel_byte   = (idx < cur_count) ? cur_bytes[idx[IW-1:0]] : cur_ctl.tail;
  assign empty      = !out_valid;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_ctl   <= cmd_ctl;
      cur_count <= cmd_count;
      cur_bytes <= cmd_bytes;
    end
    if (emit) begin
      out_byte   <= sel_byte;
      run_end    <= final_byte;
      string_end <= final_byte && cur_ctl.last;
    end
    if (rst) begin
      busy      <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (emit) begin
        if (final_byte) busy <= 1'b0;
        idx <= idx + CW'(1);
      end
      if (emit) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
    end
  end

  `HED_ASSERT_NOW(a_idx_in_run, busy, (idx < total), "byte index ran past its request")
  `HED_ASSERT_NEXT(a_load_busy, q_pop, busy, "loaded request did not start")
  `HED_ASSERT_NEXT(a_hold_out, (out_valid && !pop), (out_valid && $stable(out_byte)),
                   "waiting result changed")

endmodule

// ===== rtl/core/html_entity_decoder.sv =====
// ----------------------------------------------------------------------------
// html_entity_decoder
// Streaming decoder of named HTML character references.
// ----------------------------------------------------------------------------
// Input side is a queue write port: a byte is taken when push is high and full
// is low; in_last marks the final byte of a string. Results are read like a
// queue: while empty is low the oldest decoded byte is on out_byte, run_end
// and string_end, and it is taken when pop is high.
// An ordinary byte passes the request queue, the back end's request register
// and the output register. A ';' that closes a held name stalls the input,
// since the match against the entity table is registered before the request
// is built. Held names and replacements come out at one byte per cycle while
// the reader keeps up; a request is loaded from the two-entry queue once the
// last is done. When the reader stalls, the output register and then the
// request queue fill and full rises; nothing is lost. Reset empties the queue
// and output register and leaves the decoder outside a name.
// ----------------------------------------------------------------------------
module html_entity_decoder
  import hed_pkg::*;
#(
  parameter int BUFFER_DEPTH = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       run_end,
  output logic       string_end
);

  localparam int CW = $clog2(BUFFER_DEPTH + 2);
  localparam int CTLW = $bits(cmd_ctl_t);
  localparam int QW = CTLW + CW + 8 * BUFFER_DEPTH;

  logic                         f_push;
  logic                         q_full;
  logic                         q_empty;
  logic                         q_pop;
  cmd_ctl_t                     f_ctl;
  logic [CW-1:0]                f_count;
  logic [BUFFER_DEPTH-1:0][7:0] f_bytes;
  logic [QW-1:0]                q_out;
  cmd_ctl_t                     b_ctl;
  logic [CW-1:0]                b_count;
  logic [BUFFER_DEPTH-1:0][7:0] b_bytes;

  hed_front #(.BUFFER_DEPTH(BUFFER_DEPTH), .CW(CW)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .in_byte(in_byte), .in_last(in_last),
    .q_push(f_push), .q_full(q_full),
    .cmd_ctl(f_ctl), .cmd_count(f_count), .cmd_bytes(f_bytes)
  );

  hed_queue #(.WIDTH(QW)) u_queue (
    .clk(clk), .rst(rst),
    .push(f_push), .din({f_ctl, f_count, f_bytes}), .full(q_full),
    .pop(q_pop), .dout(q_out), .empty(q_empty)
  );

  assign b_ctl   = q_out[QW-1 -: CTLW];
  assign b_count = q_out[8*BUFFER_DEPTH +: CW];
  assign b_bytes = q_out[8*BUFFER_DEPTH-1:0];

  hed_back #(.BUFFER_DEPTH(BUFFER_DEPTH), .CW(CW)) u_back (
    .clk(clk), .rst(rst),
    .q_empty(q_empty), .q_pop(q_pop),
    .cmd_ctl(b_ctl), .cmd_count(b_count), .cmd_bytes(b_bytes),
    .empty(empty), .pop(pop),
    .out_byte(out_byte), .run_end(run_end), .string_end(string_end)
  );

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// HTML entity decoder testbench
// Streams bytes into the decoder, predicts every decoded byte with its run
// and string markers, and compares them in order against the output queue.
// ----------------------------------------------------------------------------
module testbench
  import hed_pkg::*;
();

  localparam int HOLD_MAX    = 8;
  localparam int ENTITY_ROWS = 204;

  typedef struct {
    logic [7:0] data;
    logic       run_end;
    logic       string_end;
  } decoded_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_byte = '0;
  logic       in_last = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_byte;
  logic       run_end;
  logic       string_end;

  decoded_t   decoded_q[$];
  int         mismatches = 0;
  int         bytes_sent = 0;
  bit         idling_on = 1'b1;
  bit         hold_reader = 1'b0;

  // Decoder state as the predictor sees it.
  bit         in_name = 1'b0;
  logic [7:0] name_buf[HOLD_MAX];
  int         name_cnt = 0;

  html_entity_decoder #(.BUFFER_DEPTH(HOLD_MAX)) dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_byte(in_byte),
    .in_last(in_last), .empty(empty), .pop(pop), .out_byte(out_byte),
    .run_end(run_end), .string_end(string_end)
  );

  always #6 clk = ~clk;

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic entity_at(input int i, output string nm, output int rl,
                           output logic [23:0] rp);
    rl = 2;
    case (i)
      0: begin nm = "nbsp"; rl = 1; rp = 24'h200000; end
      1: begin nm = "lt"; rl = 1; rp = 24'h3C0000; end
      2: begin nm = "gt"; rl = 1; rp = 24'h3E0000; end
      3: begin nm = "amp"; rl = 1; rp = 24'h260000; end
      4: begin nm = "quot"; rl = 1; rp = 24'h220000; end
      5: begin nm = "apos"; rl = 1; rp = 24'h270000; end
      6: begin nm = "#39"; rl = 1; rp = 24'h270000; end
      7: begin nm = "copy"; rp = 24'hC2A900; end
      8: begin nm = "reg"; rp = 24'hC2AE00; end
      9: begin nm = "trade"; rl = 3; rp = 24'hE284A2; end
      10: begin nm = "euro"; rl = 3; rp = 24'hE282AC; end
      11: begin nm = "pound"; rp = 24'hC2A300; end
      12: begin nm = "yen"; rp = 24'hC2A500; end
      13: begin nm = "cent"; rp = 24'hC2A200; end
      14: begin nm = "sect"; rp = 24'hC2A700; end
      15: begin nm = "para"; rp = 24'hC2B600; end
      16: begin nm = "middot"; rp = 24'hC2B700; end
      17: begin nm = "bull"; rl = 3; rp = 24'hE280A2; end
      18: begin nm = "hellip"; rl = 3; rp = 24'h2E2E2E; end
      19: begin nm = "ndash"; rl = 1; rp = 24'h2D0000; end
      20: begin nm = "mdash"; rl = 1; rp = 24'h2D0000; end
      21: begin nm = "laquo"; rp = 24'hC2AB00; end
      22: begin nm = "raquo"; rp = 24'hC2BB00; end
      23: begin nm = "deg"; rp = 24'hC2B000; end
      24: begin nm = "plusmn"; rp = 24'hC2B100; end
      25: begin nm = "times"; rp = 24'hC39700; end
      26: begin nm = "divide"; rp = 24'hC3B700; end
      27: begin nm = "micro"; rp = 24'hC2B500; end
      28: begin nm = "iexcl"; rp = 24'hC2A100; end
      29: begin nm = "iquest"; rp = 24'hC2BF00; end
      30: begin nm = "brvbar"; rl = 1; rp = 24'h7C0000; end
      31: begin nm = "not"; rp = 24'hC2AC00; end
      32: begin nm = "shy"; rl = 1; rp = 24'h2D0000; end
      33: begin nm = "macr"; rp = 24'hC2AF00; end
      34: begin nm = "uml"; rp = 24'hC2A800; end
      35: begin nm = "ordf"; rp = 24'hC2AA00; end
      36: begin nm = "ordm"; rp = 24'hC2BA00; end
      37: begin nm = "sup1"; rl = 1; rp = 24'h310000; end
      38: begin nm = "sup2"; rl = 1; rp = 24'h320000; end
      39: begin nm = "sup3"; rl = 1; rp = 24'h330000; end
      40: begin nm = "frac14"; rl = 3; rp = 24'h312F34; end
      41: begin nm = "frac12"; rl = 3; rp = 24'h312F32; end
      42: begin nm = "frac34"; rl = 3; rp = 24'h332F34; end
      43: begin nm = "Agrave"; rp = 24'hC38000; end
      44: begin nm = "Aacute"; rp = 24'hC38100; end
      45: begin nm = "Acirc"; rp = 24'hC38200; end
      46: begin nm = "Atilde"; rp = 24'hC38300; end
      47: begin nm = "Auml"; rp = 24'hC38400; end
      48: begin nm = "Aring"; rp = 24'hC38500; end
      49: begin nm = "AElig"; rp = 24'hC38600; end
      50: begin nm = "Ccedil"; rp = 24'hC38700; end
      51: begin nm = "Egrave"; rp = 24'hC38800; end
      52: begin nm = "Eacute"; rp = 24'hC38900; end
      53: begin nm = "Ecirc"; rp = 24'hC38A00; end
      54: begin nm = "Euml"; rp = 24'hC38B00; end
      55: begin nm = "Igrave"; rp = 24'hC38C00; end
      56: begin nm = "Iacute"; rp = 24'hC38D00; end
      57: begin nm = "Icirc"; rp = 24'hC38E00; end
      58: begin nm = "Iuml"; rp = 24'hC38F00; end
      59: begin nm = "ETH"; rp = 24'hC39000; end
      60: begin nm = "Ntilde"; rp = 24'hC39100; end
      61: begin nm = "Ograve"; rp = 24'hC39200; end
      62: begin nm = "Oacute"; rp = 24'hC39300; end
      63: begin nm = "Ocirc"; rp = 24'hC39400; end
      64: begin nm = "Otilde"; rp = 24'hC39500; end
      65: begin nm = "Ouml"; rp = 24'hC39600; end
      66: begin nm = "Oslash"; rp = 24'hC39800; end
      67: begin nm = "Ugrave"; rp = 24'hC39900; end
      68: begin nm = "Uacute"; rp = 24'hC39A00; end
      69: begin nm = "Ucirc"; rp = 24'hC39B00; end
      70: begin nm = "Uuml"; rp = 24'hC39C00; end
      71: begin nm = "Yacute"; rp = 24'hC39D00; end
      72: begin nm = "THORN"; rp = 24'hC39E00; end
      73: begin nm = "szlig"; rp = 24'hC39F00; end
      74: begin nm = "agrave"; rp = 24'hC3A000; end
      75: begin nm = "aacute"; rp = 24'hC3A100; end
      76: begin nm = "acirc"; rp = 24'hC3A200; end
      77: begin nm = "atilde"; rp = 24'hC3A300; end
      78: begin nm = "auml"; rp = 24'hC3A400; end
      79: begin nm = "aring"; rp = 24'hC3A500; end
      80: begin nm = "aelig"; rp = 24'hC3A600; end
      81: begin nm = "ccedil"; rp = 24'hC3A700; end
      82: begin nm = "egrave"; rp = 24'hC3A800; end
      83: begin nm = "eacute"; rp = 24'hC3A900; end
      84: begin nm = "ecirc"; rp = 24'hC3AA00; end
      85: begin nm = "euml"; rp = 24'hC3AB00; end
      86: begin nm = "igrave"; rp = 24'hC3AC00; end
      87: begin nm = "iacute"; rp = 24'hC3AD00; end
      88: begin nm = "icirc"; rp = 24'hC3AE00; end
      89: begin nm = "iuml"; rp = 24'hC3AF00; end
      90: begin nm = "eth"; rp = 24'hC3B000; end
      91: begin nm = "ntilde"; rp = 24'hC3B100; end
      92: begin nm = "ograve"; rp = 24'hC3B200; end
      93: begin nm = "oacute"; rp = 24'hC3B300; end
      94: begin nm = "ocirc"; rp = 24'hC3B400; end
      95: begin nm = "otilde"; rp = 24'hC3B500; end
      96: begin nm = "ouml"; rp = 24'hC3B600; end
      97: begin nm = "oslash"; rp = 24'hC3B800; end
      98: begin nm = "ugrave"; rp = 24'hC3B900; end
      99: begin nm = "uacute"; rp = 24'hC3BA00; end
      100: begin nm = "ucirc"; rp = 24'hC3BB00; end
      101: begin nm = "uuml"; rp = 24'hC3BC00; end
      102: begin nm = "yacute"; rp = 24'hC3BD00; end
      103: begin nm = "thorn"; rp = 24'hC3BE00; end
      104: begin nm = "yuml"; rp = 24'hC3BF00; end
      105: begin nm = "Alpha"; rp = 24'hCE9100; end
      106: begin nm = "Beta"; rp = 24'hCE9200; end
      107: begin nm = "Gamma"; rp = 24'hCE9300; end
      108: begin nm = "Delta"; rp = 24'hCE9400; end
      109: begin nm = "Epsilon"; rp = 24'hCE9500; end
      110: begin nm = "Zeta"; rp = 24'hCE9600; end
      111: begin nm = "Eta"; rp = 24'hCE9700; end
      112: begin nm = "Theta"; rp = 24'hCE9800; end
      113: begin nm = "Iota"; rp = 24'hCE9900; end
      114: begin nm = "Kappa"; rp = 24'hCE9A00; end
      115: begin nm = "Lambda"; rp = 24'hCE9B00; end
      116: begin nm = "Mu"; rp = 24'hCE9C00; end
      117: begin nm = "Nu"; rp = 24'hCE9D00; end
      118: begin nm = "Xi"; rp = 24'hCE9E00; end
      119: begin nm = "Omicron"; rp = 24'hCE9F00; end
      120: begin nm = "Pi"; rp = 24'hCEA000; end
      121: begin nm = "Rho"; rp = 24'hCEA100; end
      122: begin nm = "Sigma"; rp = 24'hCEA300; end
      123: begin nm = "Tau"; rp = 24'hCEA400; end
      124: begin nm = "Upsilon"; rp = 24'hCEA500; end
      125: begin nm = "Phi"; rp = 24'hCEA600; end
      126: begin nm = "Chi"; rp = 24'hCEA700; end
      127: begin nm = "Psi"; rp = 24'hCEA800; end
      128: begin nm = "Omega"; rp = 24'hCEA900; end
      129: begin nm = "alpha"; rp = 24'hCEB100; end
      130: begin nm = "beta"; rp = 24'hCEB200; end
      131: begin nm = "gamma"; rp = 24'hCEB300; end
      132: begin nm = "delta"; rp = 24'hCEB400; end
      133: begin nm = "epsilon"; rp = 24'hCEB500; end
      134: begin nm = "zeta"; rp = 24'hCEB600; end
      135: begin nm = "eta"; rp = 24'hCEB700; end
      136: begin nm = "theta"; rp = 24'hCEB800; end
      137: begin nm = "iota"; rp = 24'hCEB900; end
      138: begin nm = "kappa"; rp = 24'hCEBA00; end
      139: begin nm = "lambda"; rp = 24'hCEBB00; end
      140: begin nm = "mu"; rp = 24'hCEBC00; end
      141: begin nm = "nu"; rp = 24'hCEBD00; end
      142: begin nm = "xi"; rp = 24'hCEBE00; end
      143: begin nm = "omicron"; rp = 24'hCEBF00; end
      144: begin nm = "pi"; rp = 24'hCF8000; end
      145: begin nm = "rho"; rp = 24'hCF8100; end
      146: begin nm = "sigma"; rp = 24'hCF8300; end
      147: begin nm = "tau"; rp = 24'hCF8400; end
      148: begin nm = "upsilon"; rp = 24'hCF8500; end
      149: begin nm = "phi"; rp = 24'hCF8600; end
      150: begin nm = "chi"; rp = 24'hCF8700; end
      151: begin nm = "psi"; rp = 24'hCF8800; end
      152: begin nm = "omega"; rp = 24'hCF8900; end
      153: begin nm = "forall"; rl = 3; rp = 24'hE28880; end
      154: begin nm = "part"; rl = 3; rp = 24'hE28882; end
      155: begin nm = "exist"; rl = 3; rp = 24'hE28883; end
      156: begin nm = "empty"; rl = 3; rp = 24'hE28885; end
      157: begin nm = "nabla"; rl = 3; rp = 24'hE28887; end
      158: begin nm = "isin"; rl = 3; rp = 24'hE28888; end
      159: begin nm = "notin"; rl = 3; rp = 24'hE28889; end
      160: begin nm = "ni"; rl = 3; rp = 24'hE2888B; end
      161: begin nm = "prod"; rl = 3; rp = 24'hE2888F; end
      162: begin nm = "sum"; rl = 3; rp = 24'hE28891; end
      163: begin nm = "minus"; rl = 1; rp = 24'h2D0000; end
      164: begin nm = "lowast"; rl = 1; rp = 24'h2A0000; end
      165: begin nm = "radic"; rl = 3; rp = 24'hE2889A; end
      166: begin nm = "prop"; rl = 3; rp = 24'hE2889D; end
      167: begin nm = "infin"; rl = 3; rp = 24'hE2889E; end
      168: begin nm = "ang"; rl = 3; rp = 24'hE288A0; end
      169: begin nm = "and"; rl = 3; rp = 24'hE288A7; end
      170: begin nm = "or"; rl = 3; rp = 24'hE288A8; end
      171: begin nm = "cap"; rl = 3; rp = 24'hE288A9; end
      172: begin nm = "int"; rl = 3; rp = 24'hE288AB; end
      173: begin nm = "there4"; rl = 3; rp = 24'hE288B4; end
      174: begin nm = "cong"; rl = 3; rp = 24'hE28985; end
      175: begin nm = "asymp"; rl = 3; rp = 24'hE28988; end
      176: begin nm = "ne"; rl = 3; rp = 24'hE289A0; end
      177: begin nm = "equiv"; rl = 3; rp = 24'hE289A1; end
      178: begin nm = "le"; rl = 3; rp = 24'hE289A4; end
      179: begin nm = "ge"; rl = 3; rp = 24'hE289A5; end
      180: begin nm = "sub"; rl = 3; rp = 24'hE28A82; end
      181: begin nm = "sup"; rl = 3; rp = 24'hE28A83; end
      182: begin nm = "nsub"; rl = 3; rp = 24'hE28A84; end
      183: begin nm = "sube"; rl = 3; rp = 24'hE28A86; end
      184: begin nm = "supe"; rl = 3; rp = 24'hE28A87; end
      185: begin nm = "oplus"; rl = 3; rp = 24'hE28A95; end
      186: begin nm = "otimes"; rl = 3; rp = 24'hE28A97; end
      187: begin nm = "perp"; rl = 3; rp = 24'hE28AA5; end
      188: begin nm = "sdot"; rl = 3; rp = 24'hE28B85; end
      189: begin nm = "larr"; rl = 3; rp = 24'hE28690; end
      190: begin nm = "uarr"; rl = 3; rp = 24'hE28691; end
      191: begin nm = "rarr"; rl = 3; rp = 24'hE28692; end
      192: begin nm = "darr"; rl = 3; rp = 24'hE28693; end
      193: begin nm = "harr"; rl = 3; rp = 24'hE28694; end
      194: begin nm = "crarr"; rl = 3; rp = 24'hE286B5; end
      195: begin nm = "lArr"; rl = 3; rp = 24'hE28790; end
      196: begin nm = "uArr"; rl = 3; rp = 24'hE28791; end
      197: begin nm = "rArr"; rl = 3; rp = 24'hE28792; end
      198: begin nm = "dArr"; rl = 3; rp = 24'hE28793; end
      199: begin nm = "hArr"; rl = 3; rp = 24'hE28794; end
      200: begin nm = "spades"; rl = 3; rp = 24'hE299A0; end
      201: begin nm = "clubs"; rl = 3; rp = 24'hE299A3; end
      202: begin nm = "hearts"; rl = 3; rp = 24'hE299A5; end
      default: begin nm = "diams"; rl = 3; rp = 24'hE299A6; end
    endcase
  endtask

  task automatic emit(input logic [7:0] b);
    decoded_t d;
    d.data = b;
    d.run_end = 1'b0;
    d.string_end = 1'b0;
    decoded_q.push_back(d);
  endtask

  task automatic release_name();
    for (int k = 0; k < name_cnt; k++) emit(name_buf[k]);
    name_cnt = 0;
    in_name = 1'b0;
  endtask

  // Advances the decoder state by one accepted byte and queues its output.
  task automatic decode_byte(input logic [7:0] b, input logic last);
    int          start_len;
    int          row;
    string       nm;
    int          rl;
    logic [23:0] rp;
    bit          same;
    start_len = decoded_q.size();
    row = -1;
    if (in_name) begin
      if (b == SEMI) begin
        for (int i = 0; i < ENTITY_ROWS && row < 0; i++) begin
          entity_at(i, nm, rl, rp);
          same = (nm.len() == name_cnt - 1);
          for (int j = 0; same && j < nm.len(); j++)
            if (nm[j] != name_buf[j + 1]) same = 1'b0;
          if (same) row = i;
        end
        if (row >= 0) begin
          for (int k = 0; k < rl; k++) emit(rp[23 - 8 * k -: 8]);
          name_cnt = 0;
          in_name = 1'b0;
        end else begin
          release_name();
          emit(b);
        end
      end else if (b == AMP) begin
        release_name();
        in_name = 1'b1;
        name_buf[0] = AMP;
        name_cnt = 1;
      end else if (name_cnt < HOLD_MAX) begin
        name_buf[name_cnt] = b;
        name_cnt++;
      end else begin
        release_name();
        emit(b);
      end
    end else if (b == AMP) begin
      in_name = 1'b1;
      name_buf[0] = AMP;
      name_cnt = 1;
    end else begin
      emit(b);
    end
    if (last && in_name) release_name();
    if (decoded_q.size() > start_len) begin
      decoded_q[$].run_end = 1'b1;
      decoded_q[$].string_end = last;
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    push <= 1'b1;
    in_byte <= b;
    in_last <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    decode_byte(b, last);
    bytes_sent++;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic send_text(input string s, input bit last_at_end);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], last_at_end && (i == s.len() - 1));
  endtask

  // Reader: random stalls, plus a long hold-off when asked for.
  initial begin
    @(negedge rst);
    forever begin
      if (hold_reader) begin
        pop <= 1'b0;
        for (int c = 0; c < 400; c++) @(posedge clk);
        hold_reader = 1'b0;
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    decoded_t want;
    if (!rst && pop && !empty) begin
      if (decoded_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output byte %h run_end %b string_end %b",
                   out_byte, run_end, string_end);
      end else begin
        want = decoded_q.pop_front();
        if (out_byte !== want.data || run_end !== want.run_end ||
            string_end !== want.string_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h/%b/%b, got %h/%b/%b", want.data,
                     want.run_end, want.string_end, out_byte, run_end, string_end);
        end
      end
    end
  end

  task automatic test_entities();
    send_text("&nbsp;&hellip;&#39;&epsilon;", 1'b0);
    send_text("&spades;", 1'b1);
  endtask

  task automatic test_special_cases();
    send_text("&foo;&;&lt&gt;", 1'b0);
    // Eight held bytes, then a ninth that forces all of them out.
    send_text("&abcdefgx", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("&amp", 1'b1);
    send_text("z", 1'b1);
  endtask

  task automatic test_backpressure();
    hold_reader = 1'b1;
    for (int i = 0; i < 30; i++) send_byte(8'($urandom_range(0, 255)), i == 29);
  endtask

  task automatic test_random_text(input int count);
    string       nm;
    int          rl;
    logic [23:0] rp;
    int          stop;
    int          kind;
    stop = bytes_sent + count;
    while (bytes_sent < stop) begin
      if (stop - bytes_sent < 70) idling_on = 1'b0;
      kind = $urandom_range(0, 9);
      entity_at($urandom_range(0, ENTITY_ROWS - 1), nm, rl, rp);
      if (kind < 5) begin
        send_text({"&", nm, ";"}, $urandom_range(0, 7) == 0);
      end else if (kind == 5) begin
        // Broken name: a prefix of a name, maybe all of it, then text or a new ampersand.
        send_text({"&", nm.substr(0, $urandom_range(0, nm.len() - 1))}, 1'b0);
        send_byte($urandom_range(0, 1) ? AMP : 8'h78, $urandom_range(0, 3) == 0);
      end else if (kind == 6) begin
        send_byte(AMP, 1'b0);
        repeat ($urandom_range(0, 10))
          send_byte(8'($urandom_range(8'h61, 8'h7A)), 1'b0);
        send_byte($urandom_range(0, 1) ? SEMI : 8'h20, $urandom_range(0, 3) == 0);
      end else begin
        repeat ($urandom_range(1, 4))
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_entities();
    test_special_cases();
    test_backpressure();
    test_random_text(285);
    push <= 1'b0;
    in_last <= 1'b0;
    wait (decoded_q.size() == 0);
    repeat (30) @(posedge clk);
    if (mismatches == 0 && decoded_q.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/hed_pkg.sv
rtl/core/hed_queue.sv
rtl/core/hed_front.sv
rtl/core/hed_back.sv
rtl/core/html_entity_decoder.sv
dv/testbench.sv
